FILE: rtl/psds_pkg.sv
`timescale 1ns / 1ps

package psds_pkg;

    // Field width of value and value_res on the stream ports
    localparam int VALUE_W        = 16;
    localparam int DEF_MAX_ITEMS  = 32;
    localparam int DEF_VALUE_BITS = 16;

    // Memory halves: primes in the low half, all other values in the high half
    localparam logic REG_PRIME = 1'b0;
    localparam logic REG_OTHER = 1'b1;

    // Trial divisors: each prime whose square fits in 16 bits, then 257 last
    localparam int PRIME_W     = 9;
    localparam int PRIME_SQ_W  = 2 * PRIME_W;
    localparam int PRIME_NUM   = 55;
    localparam int PRIME_IDX_W = 6;

    localparam logic [PRIME_W-1:0] PRIME_TBL [PRIME_NUM] = '{
        9'd2,   9'd3,   9'd5,   9'd7,   9'd11,  9'd13,  9'd17,  9'd19,  9'd23,  9'd29,
        9'd31,  9'd37,  9'd41,  9'd43,  9'd47,  9'd53,  9'd59,  9'd61,  9'd67,  9'd71,
        9'd73,  9'd79,  9'd83,  9'd89,  9'd97,  9'd101, 9'd103, 9'd107, 9'd109, 9'd113,
        9'd127, 9'd131, 9'd137, 9'd139, 9'd149, 9'd151, 9'd157, 9'd163, 9'd167, 9'd173,
        9'd179, 9'd181, 9'd191, 9'd193, 9'd197, 9'd199, 9'd211, 9'd223, 9'd227, 9'd229,
        9'd233, 9'd239, 9'd241, 9'd251, 9'd257
    };

    // Stored value width: the low VALUE_BITS of the field, at most the field itself
    function automatic int store_w(input int bits);
        return (bits < VALUE_W) ? bits : VALUE_W;
    endfunction

    // Trial divisor lookup, clamped to the last entry
    function automatic logic [PRIME_W-1:0] prime_at(input logic [PRIME_IDX_W-1:0] k);
        logic [PRIME_W-1:0] p;
        p = PRIME_TBL[PRIME_NUM-1];
        if (k < PRIME_IDX_W'(PRIME_NUM)) begin
            p = PRIME_TBL[k];
        end
        return p;
    endfunction

    // Controller to datapath commands
    typedef struct packed {
        logic load;            // input request accepted
        logic cl_rd;           // read raw value for classification
        logic cl_go;           // latch raw value, start prime test
        logic cl_store;        // file classified value into its region
        logic so_begin;        // start sorting the prime region
        logic so_rdi;          // read the head entry of the unsorted tail
        logic so_next_region;  // move sorting to the other region
        logic so_ldi;          // latch head entry, start the scan
        logic so_scan;         // one scan step
        logic so_sw1;          // write the maximum to the head slot
        logic so_sw2;          // write the old head to the maximum's slot
        logic em_init;         // pick first nonempty region for output
        logic em_rd;           // read the next result
        logic em_ld;           // load the output register
        logic clear;           // clear counts and flags
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic pt_done;         // prime test finished
        logic cl_last;         // current raw entry is the last one
        logic outer_done;      // tail of current region has at most one entry
        logic region;          // region currently sorted
        logic scan_more;       // scan still has entries to read
        logic out_taken;       // output request accepted this cycle
        logic out_last;        // output register holds the final result
    } t_dp_sts;

endpackage

FILE: rtl/prime_split_descending_sort_unit.sv
`timescale 1ns / 1ps

// Prime split and descending sort.
// Slave stream: one value per request, tlast closes the set. Values are
// taken one per cycle while the block is loading; tready then drops until
// the whole set has been delivered. Up to MAX_ITEMS values are kept, later
// ones in the same set are dropped and the overflow flag is raised.
// After tlast each value is tested by trial division against a prime table,
// one remainder bit of the SW-bit stored value per cycle (SW is the stored
// width, at most 16), up to 54 primes for a 16-bit value. Each half is then
// selection sorted in place in the shared memory. Master stream: primes
// first, then the rest, each group descending, with tuser carrying the
// prime flag and the overflow flag, tlast on the final result. The next
// result is read and loaded only after the previous one is taken; when the
// receiver stalls the result holds in the output register. After the final
// result is taken the block loads the next set on the following cycle.
// Reset (synchronous) empties the set and returns to loading.
module prime_split_descending_sort_unit #(
    parameter int MAX_ITEMS  = psds_pkg::DEF_MAX_ITEMS,
    parameter int VALUE_BITS = psds_pkg::DEF_VALUE_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // slave stream
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [psds_pkg::VALUE_W-1:0] i_s_axis_tdata,   // [15:0] value
    input  logic                         i_s_axis_tlast,
    // master stream
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    output logic [psds_pkg::VALUE_W-1:0] o_m_axis_tdata,   // [15:0] value_res
    output logic [1:0]                   o_m_axis_tuser,   // [0] is_prime, [1] overflow
    output logic                         o_m_axis_tlast
);
    import psds_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    out_prime, out_ovf;

    psds_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_last  (i_s_axis_tlast),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    psds_datapath #(
        .MAX_ITEMS  (MAX_ITEMS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_value     (i_s_axis_tdata),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_value (o_m_axis_tdata),
        .o_out_prime (out_prime),
        .o_out_last  (o_m_axis_tlast),
        .o_out_ovf   (out_ovf)
    );

    assign o_m_axis_tuser = {out_ovf, out_prime};

    // Loading and delivery never overlap
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !o_s_axis_tready)
        else $error("input ready while a result is pending");

    // A set's closing request stops intake
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast) |=> !o_s_axis_tready)
        else $error("intake continued after the closing request");

    // Taking the final result reopens intake
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast) |=> o_s_axis_tready)
        else $error("intake not reopened after the final result");

    // Only one memory write source per cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.cl_store, cmd.so_sw1, cmd.so_sw2}))
        else $error("conflicting memory writes");

endmodule

FILE: rtl/psds_ram.sv
`timescale 1ns / 1ps

module psds_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/psds_prime_test.sv
`timescale 1ns / 1ps

module psds_prime_test #(
    parameter int VALUE_BITS = psds_pkg::DEF_VALUE_BITS
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_start,
    input  logic [psds_pkg::store_w(VALUE_BITS)-1:0]   i_value,
    output logic                                       o_done,
    output logic                                       o_is_prime
);
    import psds_pkg::*;

    localparam int SW    = store_w(VALUE_BITS);
    localparam int BIT_W = $clog2(SW);

    localparam logic [1:0] PT_IDLE  = 2'd0;
    localparam logic [1:0] PT_CHECK = 2'd1;
    localparam logic [1:0] PT_DIV   = 2'd2;
    localparam logic [1:0] PT_DONE  = 2'd3;

    logic [1:0]             r_state, n_state;
    logic [SW-1:0]          r_v, n_v;
    logic [PRIME_IDX_W-1:0] r_k, n_k;
    logic [PRIME_W-1:0]     r_rem, n_rem;
    logic [BIT_W-1:0]       r_bit, n_bit;
    logic                   r_res, n_res;

    logic [PRIME_W-1:0]     p;
    logic [PRIME_SQ_W-1:0]  p_sq;
    logic [PRIME_SQ_W-1:0]  v_ext;
    logic [PRIME_W:0]       rem_sh;
    logic [PRIME_W:0]       rem_sub;

    // Trial division by successive primes, remainder one bit per cycle
    always_comb begin
        p       = prime_at(r_k);
        p_sq    = PRIME_SQ_W'(p) * PRIME_SQ_W'(p);
        v_ext   = PRIME_SQ_W'(r_v);
        rem_sh  = {r_rem, r_v[r_bit]};
        rem_sub = rem_sh - {1'b0, p};

        n_state = r_state;
        n_v     = r_v;
        n_k     = r_k;
        n_rem   = r_rem;
        n_bit   = r_bit;
        n_res   = r_res;

        unique case (r_state)
            PT_IDLE: begin
                if (i_start) begin
                    n_v = i_value;
                    n_k = '0;
                    if (i_value < SW'(2)) begin
                        n_res   = 1'b0;
                        n_state = PT_DONE;
                    end else begin
                        n_state = PT_CHECK;
                    end
                end
            end
            PT_CHECK: begin
                // divisor above the square root: no factor left
                if (p_sq > v_ext) begin
                    n_res   = 1'b1;
                    n_state = PT_DONE;
                end else begin
                    n_rem   = '0;
                    n_bit   = BIT_W'(SW - 1);
                    n_state = PT_DIV;
                end
            end
            PT_DIV: begin
                if (rem_sh >= {1'b0, p}) begin
                    n_rem = rem_sub[PRIME_W-1:0];
                end else begin
                    n_rem = rem_sh[PRIME_W-1:0];
                end
                if (r_bit == '0) begin
                    if (n_rem == '0) begin
                        n_res   = 1'b0;
                        n_state = PT_DONE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = PT_CHECK;
                    end
                end else begin
                    n_bit = r_bit - 1'b1;
                end
            end
            PT_DONE: begin
                n_state = PT_IDLE;
            end
            default: begin
                n_state = PT_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PT_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v   <= n_v;
        r_k   <= n_k;
        r_rem <= n_rem;
        r_bit <= n_bit;
        r_res <= n_res;
    end

    assign o_done     = (r_state == PT_DONE);
    assign o_is_prime = r_res;

endmodule

FILE: rtl/psds_datapath.sv
`timescale 1ns / 1ps

module psds_datapath #(
    parameter int MAX_ITEMS  = psds_pkg::DEF_MAX_ITEMS,
    parameter int VALUE_BITS = psds_pkg::DEF_VALUE_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  psds_pkg::t_dp_cmd            i_cmd,
    output psds_pkg::t_dp_sts            o_sts,
    input  logic [psds_pkg::VALUE_W-1:0] i_value,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [psds_pkg::VALUE_W-1:0] o_out_value,
    output logic                         o_out_prime,
    output logic                         o_out_last,
    output logic                         o_out_ovf
);
    import psds_pkg::*;

    localparam int SW     = store_w(VALUE_BITS);
    localparam int IDX_W  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int ADDR_W = IDX_W + 1;
    localparam int DEPTH  = 2 ** ADDR_W;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITEMS);

    logic [CNT_W-1:0]  r_n, r_pc, r_oc, r_i, r_j, r_best_idx;
    logic              r_region;
    logic              r_dropped;
    logic [SW-1:0]     r_cur_val, r_best_val;
    logic              r_out_valid;
    logic [SW-1:0]     r_out_data;
    logic              r_out_prime, r_out_last, r_out_ovf;

    logic [SW-1:0]     vin;
    logic [SW-1:0]     rd_data;
    logic              we;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [SW-1:0]     wdata;
    logic [CNT_W-1:0]  c_cur, i_inc, j_prev;
    logic              em_last;
    logic              scan_more;
    logic              out_taken;
    logic              pt_done, pt_prime;
    logic [VALUE_W-1:0] out_ext;

    assign vin       = i_value[SW-1:0];
    assign c_cur     = r_region ? r_oc : r_pc;
    assign i_inc     = r_i + 1'b1;
    assign j_prev    = r_j - 1'b1;
    assign scan_more = (r_j < c_cur);
    assign out_taken = r_out_valid & i_out_ready;
    assign em_last   = (r_region == REG_OTHER) ? (i_inc == r_oc)
                                               : ((i_inc == r_pc) && (r_oc == '0));

    psds_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    psds_prime_test #(
        .VALUE_BITS (VALUE_BITS)
    ) u_prime_test (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.cl_go),
        .i_value    (rd_data),
        .o_done     (pt_done),
        .o_is_prime (pt_prime)
    );

    // Memory port steering
    always_comb begin
        we    = 1'b0;
        waddr = {r_region, r_i[IDX_W-1:0]};
        wdata = r_cur_val;
        raddr = {r_region, r_i[IDX_W-1:0]};

        if (i_cmd.load && (r_n < CNT_MAX)) begin
            we    = 1'b1;
            waddr = {REG_OTHER, r_n[IDX_W-1:0]};
            wdata = vin;
        end
        if (i_cmd.cl_rd) begin
            raddr = {REG_OTHER, r_i[IDX_W-1:0]};
        end
        // others compact in place: their slot never passes the read index
        if (i_cmd.cl_store) begin
            we    = 1'b1;
            waddr = pt_prime ? {REG_PRIME, r_pc[IDX_W-1:0]}
                             : {REG_OTHER, r_oc[IDX_W-1:0]};
            wdata = r_cur_val;
        end
        if (i_cmd.so_ldi || i_cmd.so_scan) begin
            raddr = {r_region, r_j[IDX_W-1:0]};
        end
        if (i_cmd.so_sw1) begin
            we    = 1'b1;
            waddr = {r_region, r_i[IDX_W-1:0]};
            wdata = r_best_val;
        end
        if (i_cmd.so_sw2) begin
            we    = 1'b1;
            waddr = {r_region, r_best_idx[IDX_W-1:0]};
            wdata = r_cur_val;
        end
    end

    // Counters, flags and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n         <= '0;
            r_pc        <= '0;
            r_oc        <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_region    <= REG_PRIME;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (r_n < CNT_MAX) begin
                    r_n <= r_n + 1'b1;
                end else begin
                    r_dropped <= 1'b1;
                end
            end
            if (i_cmd.cl_store) begin
                if (pt_prime) begin
                    r_pc <= r_pc + 1'b1;
                end else begin
                    r_oc <= r_oc + 1'b1;
                end
                r_i <= i_inc;
            end
            if (i_cmd.so_begin) begin
                r_region <= REG_PRIME;
                r_i      <= '0;
            end
            if (i_cmd.so_next_region) begin
                r_region <= REG_OTHER;
                r_i      <= '0;
            end
            if (i_cmd.so_rdi) begin
                r_j <= i_inc;
            end
            if (i_cmd.so_ldi || (i_cmd.so_scan && scan_more)) begin
                r_j <= r_j + 1'b1;
            end
            if (i_cmd.so_sw2) begin
                r_i <= i_inc;
            end
            if (i_cmd.em_init) begin
                r_region <= (r_pc == '0) ? REG_OTHER : REG_PRIME;
                r_i      <= '0;
            end
            // output register; emit order walks primes, then others
            if (i_cmd.em_ld) begin
                r_out_valid <= 1'b1;
                if ((r_region == REG_PRIME) && (i_inc == r_pc)) begin
                    r_region <= REG_OTHER;
                    r_i      <= '0;
                end else begin
                    r_i <= i_inc;
                end
            end else if (out_taken) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.clear) begin
                r_n       <= '0;
                r_pc      <= '0;
                r_oc      <= '0;
                r_i       <= '0;
                r_dropped <= 1'b0;
            end
        end
    end

    // Value registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.cl_go) begin
            r_cur_val <= rd_data;
        end
        if (i_cmd.so_ldi) begin
            r_cur_val  <= rd_data;
            r_best_val <= rd_data;
            r_best_idx <= r_i;
        end
        // strict compare keeps the first of equal maxima
        if (i_cmd.so_scan && (rd_data > r_best_val)) begin
            r_best_val <= rd_data;
            r_best_idx <= j_prev;
        end
        if (i_cmd.em_ld) begin
            r_out_data  <= rd_data;
            r_out_prime <= (r_region == REG_PRIME);
            r_out_last  <= em_last;
            r_out_ovf   <= r_dropped;
        end
    end

    always_comb begin
        out_ext         = '0;
        out_ext[SW-1:0] = r_out_data;
    end

    assign o_sts.pt_done    = pt_done;
    assign o_sts.cl_last    = (i_inc == r_n);
    assign o_sts.outer_done = (i_inc >= c_cur);
    assign o_sts.region     = r_region;
    assign o_sts.scan_more  = scan_more;
    assign o_sts.out_taken  = out_taken;
    assign o_sts.out_last   = r_out_last;

    assign o_out_valid = r_out_valid;
    assign o_out_value = out_ext;
    assign o_out_prime = r_out_prime;
    assign o_out_last  = r_out_last;
    assign o_out_ovf   = r_out_ovf;

endmodule

FILE: rtl/psds_ctrl.sv
`timescale 1ns / 1ps

module psds_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_last,
    output logic              o_in_ready,
    output psds_pkg::t_dp_cmd o_cmd,
    input  psds_pkg::t_dp_sts i_sts
);
    import psds_pkg::*;

    localparam logic [3:0] ST_LOAD     = 4'd0;
    localparam logic [3:0] ST_CL_RD    = 4'd1;
    localparam logic [3:0] ST_CL_GO    = 4'd2;
    localparam logic [3:0] ST_CL_WAIT  = 4'd3;
    localparam logic [3:0] ST_SO_BEGIN = 4'd4;
    localparam logic [3:0] ST_SO_CHK   = 4'd5;
    localparam logic [3:0] ST_SO_LDI   = 4'd6;
    localparam logic [3:0] ST_SO_SCAN  = 4'd7;
    localparam logic [3:0] ST_SO_SW1   = 4'd8;
    localparam logic [3:0] ST_SO_SW2   = 4'd9;
    localparam logic [3:0] ST_EM_INIT  = 4'd10;
    localparam logic [3:0] ST_EM_RD    = 4'd11;
    localparam logic [3:0] ST_EM_LD    = 4'd12;
    localparam logic [3:0] ST_EM_WAIT  = 4'd13;

    logic [3:0] r_state, n_state;

    // Phase sequencing: load, classify, sort both regions, emit
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;

        unique case (r_state)
            ST_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_in_last) begin
                        n_state = ST_CL_RD;
                    end
                end
            end
            ST_CL_RD: begin
                o_cmd.cl_rd = 1'b1;
                n_state     = ST_CL_GO;
            end
            ST_CL_GO: begin
                o_cmd.cl_go = 1'b1;
                n_state     = ST_CL_WAIT;
            end
            ST_CL_WAIT: begin
                if (i_sts.pt_done) begin
                    o_cmd.cl_store = 1'b1;
                    n_state        = i_sts.cl_last ? ST_SO_BEGIN : ST_CL_RD;
                end
            end
            ST_SO_BEGIN: begin
                o_cmd.so_begin = 1'b1;
                n_state        = ST_SO_CHK;
            end
            ST_SO_CHK: begin
                if (i_sts.outer_done) begin
                    if (i_sts.region == REG_PRIME) begin
                        o_cmd.so_next_region = 1'b1;
                    end else begin
                        n_state = ST_EM_INIT;
                    end
                end else begin
                    o_cmd.so_rdi = 1'b1;
                    n_state      = ST_SO_LDI;
                end
            end
            ST_SO_LDI: begin
                o_cmd.so_ldi = 1'b1;
                n_state      = ST_SO_SCAN;
            end
            ST_SO_SCAN: begin
                o_cmd.so_scan = 1'b1;
                if (!i_sts.scan_more) begin
                    n_state = ST_SO_SW1;
                end
            end
            ST_SO_SW1: begin
                o_cmd.so_sw1 = 1'b1;
                n_state      = ST_SO_SW2;
            end
            ST_SO_SW2: begin
                o_cmd.so_sw2 = 1'b1;
                n_state      = ST_SO_CHK;
            end
            ST_EM_INIT: begin
                o_cmd.em_init = 1'b1;
                n_state       = ST_EM_RD;
            end
            ST_EM_RD: begin
                o_cmd.em_rd = 1'b1;
                n_state     = ST_EM_LD;
            end
            ST_EM_LD: begin
                o_cmd.em_ld = 1'b1;
                n_state     = ST_EM_WAIT;
            end
            ST_EM_WAIT: begin
                if (i_sts.out_taken) begin
                    if (i_sts.out_last) begin
                        o_cmd.clear = 1'b1;
                        n_state     = ST_LOAD;
                    end else begin
                        o_cmd.em_rd = 1'b1;
                        n_state     = ST_EM_LD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: sim/prime_split_descending_sort_checker.sv
`timescale 1ns / 1ps

// Watches both stream ports of the prime split sort unit, rebuilds every set
// from the accepted input requests and queues the ordered results it must
// deliver: primes first, then the rest, each group in descending order.
module prime_split_descending_sort_checker #(
    parameter int CAPACITY = psds_pkg::DEF_MAX_ITEMS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // slave side of the block
    input  logic                         i_s_tvalid,
    input  logic                         i_s_tready,
    input  logic [psds_pkg::VALUE_W-1:0] i_s_tdata,    // [15:0] value
    input  logic                         i_s_tlast,
    // master side of the block
    input  logic                         i_m_tvalid,
    input  logic                         i_m_tready,
    input  logic [psds_pkg::VALUE_W-1:0] i_m_tdata,    // [15:0] value_res
    input  logic [1:0]                   i_m_tuser,    // [0] is_prime, [1] overflow
    input  logic                         i_m_tlast,
    // status toward the testbench top
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_sets,
    output int                           o_requests,
    output int                           o_results,
    output int                           o_overflow_sets
);

    import psds_pkg::*;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               prime;
        logic               overflow;
        logic               end_of_run;
    } t_sorted_res;

    t_sorted_res        sorted_q[$];

    // Current set as loaded so far
    logic [VALUE_W-1:0] set_val   [CAPACITY];
    logic               set_prime [CAPACITY];
    bit                 set_taken [CAPACITY];
    int                 set_n         = 0;
    bit                 set_dropped   = 1'b0;

    int                 fails         = 0;
    int                 sets_done     = 0;
    int                 requests_in   = 0;
    int                 results_out   = 0;
    int                 overflow_sets = 0;

    // Trial division; 0 and 1 are not prime
    function automatic bit value_is_prime(input int unsigned v);
        int unsigned d;
        if (v < 2) begin
            return 1'b0;
        end
        for (d = 2; d * d <= v; d++) begin
            if (v % d == 0) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        fails++;
        if (fails <= 30) begin
            $display("ERROR: result %0d: %s got %0h, want %0h", results_out, what, got, want);
        end
    endtask

    // Close the set: pick entries in output order (prime class first, then
    // larger value first) and queue them; the last one carries tlast.
    task automatic close_set();
        int i;
        int k;
        int best;
        t_sorted_res r;
        for (i = 0; i < set_n; i++) begin
            set_taken[i] = 1'b0;
        end
        for (k = 0; k < set_n; k++) begin
            best = -1;
            for (i = 0; i < set_n; i++) begin
                if (!set_taken[i] && (best < 0 ||
                    (set_prime[i] && !set_prime[best]) ||
                    (set_prime[i] == set_prime[best] && set_val[i] > set_val[best]))) begin
                    best = i;
                end
            end
            set_taken[best] = 1'b1;
            r.value      = set_val[best];
            r.prime      = set_prime[best];
            r.overflow   = set_dropped;
            r.end_of_run = (k == set_n - 1);
            sorted_q.push_back(r);
        end
        if (set_dropped) begin
            overflow_sets++;
        end
        sets_done++;
        set_n       = 0;
        set_dropped = 1'b0;
    endtask

    // Sample both channels at each edge
    always @(posedge i_clk) begin
        t_sorted_res want;
        if (i_rst_n) begin
            // input request: store or drop, then close on tlast
            if (i_s_tvalid && i_s_tready) begin
                requests_in++;
                if (set_n < CAPACITY) begin
                    set_val[set_n]   = i_s_tdata;
                    set_prime[set_n] = value_is_prime(32'(i_s_tdata));
                    set_n++;
                end else begin
                    set_dropped = 1'b1;
                end
                if (i_s_tlast) begin
                    close_set();
                end
            end
            // output request: compare with the oldest queued result
            if (i_m_tvalid && i_m_tready) begin
                if (sorted_q.size() == 0) begin
                    report_mismatch("value with none pending", int'(i_m_tdata), 0);
                end else begin
                    want = sorted_q.pop_front();
                    if (i_m_tdata !== want.value) begin
                        report_mismatch("value", int'(i_m_tdata), int'(want.value));
                    end
                    if (i_m_tuser[0] !== want.prime) begin
                        report_mismatch("is_prime", int'(i_m_tuser[0]), int'(want.prime));
                    end
                    if (i_m_tuser[1] !== want.overflow) begin
                        report_mismatch("overflow", int'(i_m_tuser[1]), int'(want.overflow));
                    end
                    if (i_m_tlast !== want.end_of_run) begin
                        report_mismatch("end_of_run", int'(i_m_tlast), int'(want.end_of_run));
                    end
                end
                results_out++;
            end
        end
        o_fail_count    <= fails;
        o_pending       <= sorted_q.size();
        o_sets          <= sets_done;
        o_requests      <= requests_in;
        o_results       <= results_out;
        o_overflow_sets <= overflow_sets;
    end

endmodule

FILE: sim/tb_prime_split_descending_sort_unit.sv
`timescale 1ns / 1ps

// Drives sets of values into the prime split sort unit with random gaps on
// both sides; the checker beside the block predicts and compares results.
module tb_prime_split_descending_sort_unit;

    import psds_pkg::*;

    localparam int CAPACITY     = DEF_MAX_ITEMS;
    localparam int RANDOM_ITEMS = 320;
    localparam int HOLD_CYCLES  = 600;
    localparam int CYCLE_LIMIT  = 3_000_000;

    logic               i_clk;
    logic               i_rst_n         = 1'b0;
    logic               s_tvalid        = 1'b0;
    logic               s_tready;
    logic [VALUE_W-1:0] s_tdata         = '0;
    logic               s_tlast         = 1'b0;
    logic               m_tvalid;
    logic               m_tready        = 1'b0;
    logic [VALUE_W-1:0] m_tdata;
    logic [1:0]         m_tuser;
    logic               m_tlast;

    int                 chk_fails;
    int                 chk_pending;
    int                 chk_sets;
    int                 chk_requests;
    int                 chk_results;
    int                 chk_overflow_sets;

    int                 tx_idle_pct     = 14;
    int                 rx_idle_pct     = 88;
    bit                 long_hold_due   = 1'b0;
    int                 cycle_count     = 0;
    int                 sent            = 0;

    prime_split_descending_sort_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),      // [15:0] value
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),      // [15:0] value_res
        .o_m_axis_tuser  (m_tuser),      // [0] is_prime, [1] overflow
        .o_m_axis_tlast  (m_tlast)
    );

    prime_split_descending_sort_checker #(
        .CAPACITY (CAPACITY)
    ) i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (s_tvalid),
        .i_s_tready      (s_tready),
        .i_s_tdata       (s_tdata),
        .i_s_tlast       (s_tlast),
        .i_m_tvalid      (m_tvalid),
        .i_m_tready      (m_tready),
        .i_m_tdata       (m_tdata),
        .i_m_tuser       (m_tuser),
        .i_m_tlast       (m_tlast),
        .o_fail_count    (chk_fails),
        .o_pending       (chk_pending),
        .o_sets          (chk_sets),
        .o_requests      (chk_requests),
        .o_results       (chk_results),
        .o_overflow_sets (chk_overflow_sets)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever begin
            #10 i_clk = ~i_clk;
        end
    end

    // Reset, once
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("prime_split_descending_sort_unit: mismatch");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off once a result waits
    initial begin
        forever begin
            @(posedge i_clk);
            if (long_hold_due) begin
                long_hold_due = 1'b0;
                m_tready <= 1'b0;
                while (!m_tvalid) @(posedge i_clk);
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // One input request, with random idle cycles ahead of it
    task automatic send_item(input logic [VALUE_W-1:0] v, input logic l);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= l;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sent++;
    endtask

    // Mix of tiny values, mid values, values near the top and full range
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0, 1, 2: return VALUE_W'($urandom_range(64));
            3, 4:    return VALUE_W'($urandom_range(1000));
            5:       return 16'hFFFF - VALUE_W'($urandom_range(40));
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    // Stimulus and verdict
    initial begin
        logic [VALUE_W-1:0] directed [18];
        int set_len;
        int set_idx;
        int i;

        directed = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd65521, 16'd65535, 16'd9,
                     16'd25, 16'd49, 16'd2, 16'd32768, 16'd7919, 16'd65535, 16'd4,
                     16'd65535, 16'd2, 16'd1};

        while (!i_rst_n) @(posedge i_clk);

        // Directed sets: a lone zero, a mixed set with duplicates and the
        // extremes, a lone non-prime maximum, a lone prime, a lone one
        send_item(directed[0], 1'b1);
        for (i = 1; i < 15; i++) begin
            send_item(directed[i], i == 14);
        end
        send_item(directed[15], 1'b1);
        send_item(directed[16], 1'b1);
        send_item(directed[17], 1'b1);

        // Random sets; first one overflows with a dropped tlast item, the
        // second one fills the stores exactly
        set_idx = 0;
        sent    = 0;
        while (sent < RANDOM_ITEMS) begin
            if (tx_idle_pct == 14 && sent >= RANDOM_ITEMS / 3) begin
                tx_idle_pct = 88;
                rx_idle_pct = 14;
            end else if (tx_idle_pct == 88 && sent >= 2 * RANDOM_ITEMS / 3) begin
                // let every pending result drain before the last phase
                s_tvalid <= 1'b0;
                @(posedge i_clk);
                while (chk_pending != 0) @(posedge i_clk);
                tx_idle_pct   = 0;
                rx_idle_pct   = 0;
                long_hold_due = 1'b1;
            end
            if (set_idx == 0) begin
                set_len = CAPACITY + 2;
            end else if (set_idx == 1) begin
                set_len = CAPACITY;
            end else begin
                case ($urandom_range(19))
                    0, 1:    set_len = CAPACITY + 1 + $urandom_range(7);
                    2:       set_len = CAPACITY;
                    3, 4, 5: set_len = 9 + $urandom_range(CAPACITY - 10);
                    default: set_len = 1 + $urandom_range(7);
                endcase
            end
            for (i = 0; i < set_len; i++) begin
                send_item(pick_value(), i == set_len - 1);
            end
            set_idx++;
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        @(posedge i_clk);
        while (chk_pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("sets: %0d (%0d with dropped values), requests in: %0d, results out: %0d",
                 chk_sets, chk_overflow_sets, chk_requests, chk_results);
        $display("idle mixes: sender-light, receiver-light, none; one %0d-cycle output hold",
                 HOLD_CYCLES);
        if (chk_fails == 0 && chk_pending == 0) begin
            $display("prime_split_descending_sort_unit: match");
        end else begin
            $display("prime_split_descending_sort_unit: mismatch");
        end
        $finish;
    end

endmodule
